// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TASKS      = 8;
    localparam int DELAY_BITS = 16;
    localparam int IDX_W      = $clog2(TASKS + 1);
    localparam int WALK_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_SUSPEND = 3'd1;
    localparam logic [2:0] KIND_RESUME  = 3'd2;
    localparam logic [2:0] KIND_DELAY   = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;
    localparam logic [2:0] KIND_START   = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  task_req;
        logic [15:0] ticks;
    } cmd_word_t;

    typedef struct packed {
        logic [3:0]  running_task;
        logic        switch_request;
        logic [31:0] tick_total;
    } rsp_word_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CREATE,
        OP_SUSPEND,
        OP_RESUME,
        OP_DELAY,
        OP_TICK,
        OP_START
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [IDX_W-1:0]      slot;
        logic [DELAY_BITS-1:0] dly;
    } op_word_t;

    // handshake between queue and execution side
    typedef struct packed {
        logic     valid;
        op_word_t word;
    } q_head_t;

endpackage

// ----- rtl/pts_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_front
// Input stage: takes command words, decodes them into internal operations and
// hands them to the queue.
// ----------------------------------------------------------------------------
module pts_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  pts_pkg::cmd_word_t  cmd_word,
    input  logic                q_full,
    output logic                push,
    output pts_pkg::op_word_t   push_word
);
    import pts_pkg::*;

    logic     stage_valid_reg;
    logic     stage_valid_next;
    op_word_t stage_word_reg;
    op_word_t stage_word_next;
    op_word_t decoded;
    logic     req_ok;
    logic     accept;

    always_comb
    begin
        req_ok       = 32'(cmd_word.task_req) <= 32'(TASKS);
        decoded.slot = IDX_W'(cmd_word.task_req);
        decoded.dly  = DELAY_BITS'(cmd_word.ticks);
        decoded.op   = OP_NOP;
        unique case (cmd_word.kind)
            KIND_CREATE:  decoded.op = req_ok ? OP_CREATE : OP_NOP;
            KIND_SUSPEND: decoded.op = req_ok ? OP_SUSPEND : OP_NOP;
            KIND_RESUME:  decoded.op = req_ok ? OP_RESUME : OP_NOP;
            // zero-length delay is a no-op
            KIND_DELAY:   decoded.op = (decoded.dly != '0) ? OP_DELAY : OP_NOP;
            KIND_TICK:    decoded.op = OP_TICK;
            KIND_START:   decoded.op = OP_START;
            default:      decoded.op = OP_NOP;
        endcase
    end

    assign cmd_stall = stage_valid_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = stage_valid_reg && !q_full;
    assign push_word = stage_word_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_word_next  = stage_word_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_word_next  = decoded;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_word_reg <= stage_word_next;
    end

endmodule

// ----- rtl/pts_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_queue
// Short FIFO of decoded operations between the input and execution sides.
// ----------------------------------------------------------------------------
module pts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pts_pkg::op_word_t  push_word,
    output logic               full,
    input  logic               pop,
    output pts_pkg::q_head_t   head
);
    import pts_pkg::*;

    op_word_t            mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head.valid = count_reg != '0;
    assign head.word  = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/pts_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_back
// Execution side: holds the task table, walks delay counters on ticks, picks
// the next running task and registers the result word.
// ----------------------------------------------------------------------------
module pts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::q_head_t   head,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pts_pkg::rsp_word_t rsp_word
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PICK
    } state_t;

    typedef enum logic [1:0] {
        MODE_READY,
        MODE_DELAY,
        MODE_SUSPEND
    } mode_t;

    state_t                state_reg, state_next;
    logic [WALK_W-1:0]     walk_reg, walk_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [TASKS-1:0]      ready_reg, ready_next;
    mode_t                 mode_reg [TASKS];
    mode_t                 mode_next [TASKS];
    logic [DELAY_BITS-1:0] delay_reg [TASKS];
    logic [DELAY_BITS-1:0] delay_next [TASKS];
    logic                  slicing_reg, slicing_next;
    logic [31:0]           tick_reg, tick_next;
    logic                  sw_reg, sw_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_word_t             out_word_reg, out_word_next;

    logic                  out_free;
    logic                  emit;
    logic                  emit_sw;
    logic                  slot_real;
    logic                  slot_is_cur;
    logic [WALK_W-1:0]     slot_lo;
    logic [WALK_W-1:0]     cur_lo;
    logic [IDX_W-1:0]      pick;
    logic [DELAY_BITS-1:0] dec;
    logic [TASKS-1:0]      held_vec;

    // lowest ready slot wins, idle slot when none
    always_comb
    begin
        pick = IDX_W'(TASKS);
        for (int i = TASKS - 1; i >= 0; i--)
        begin
            if (ready_reg[i])
            begin
                pick = IDX_W'(i);
            end
        end
    end

    assign out_free    = !out_valid_reg || !rsp_stall;
    assign slot_real   = head.word.slot < IDX_W'(TASKS);
    assign slot_is_cur = head.word.slot == cur_reg;
    assign slot_lo     = head.word.slot[WALK_W-1:0];
    assign cur_lo      = cur_reg[WALK_W-1:0];
    assign dec         = delay_reg[walk_reg] - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        cur_next     = cur_reg;
        ready_next   = ready_reg;
        mode_next    = mode_reg;
        delay_next   = delay_reg;
        slicing_next = slicing_reg;
        tick_next    = tick_reg;
        sw_next      = sw_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        emit_sw      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    case (head.word.op) inside
                        OP_CREATE:
                        begin
                            if (slot_real)
                            begin
                                ready_next[slot_lo] = 1'b1;
                                mode_next[slot_lo]  = MODE_READY;
                                delay_next[slot_lo] = '0;
                            end
                            emit = 1'b1;
                        end
                        OP_SUSPEND, OP_RESUME:
                        begin
                            if (slot_real)
                            begin
                                ready_next[slot_lo] = head.word.op == OP_RESUME;
                                mode_next[slot_lo]  = (head.word.op == OP_RESUME)
                                                      ? MODE_READY : MODE_SUSPEND;
                                delay_next[slot_lo] = '0;
                            end
                            if (slot_is_cur)
                            begin
                                sw_next    = 1'b1;
                                state_next = S_PICK;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_DELAY:
                        begin
                            // the idle slot keeps no table entry
                            if (cur_reg < IDX_W'(TASKS))
                            begin
                                ready_next[cur_lo] = 1'b0;
                                mode_next[cur_lo]  = MODE_DELAY;
                                delay_next[cur_lo] = head.word.dly;
                            end
                            sw_next    = 1'b1;
                            state_next = S_PICK;
                        end
                        OP_TICK:
                        begin
                            tick_next = tick_reg + 32'd1;
                            if (slicing_reg)
                            begin
                                sw_next    = 1'b1;
                                walk_next  = '0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            slicing_next = 1'b1;
                            sw_next      = 1'b0;
                            state_next   = S_PICK;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (mode_reg[walk_reg] == MODE_DELAY)
                begin
                    delay_next[walk_reg] = dec;
                    if (dec == '0)
                    begin
                        mode_next[walk_reg]  = MODE_READY;
                        ready_next[walk_reg] = 1'b1;
                    end
                end
                if (walk_reg == WALK_W'(TASKS - 1))
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                cur_next   = pick;
                emit       = 1'b1;
                emit_sw    = sw_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && rsp_stall;
        out_word_next  = out_word_reg;
        if (emit)
        begin
            out_valid_next              = 1'b1;
            out_word_next.running_task  = 4'(cur_next);
            out_word_next.switch_request = emit_sw;
            out_word_next.tick_total    = tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_reg      <= '0;
            cur_reg       <= IDX_W'(TASKS);
            ready_reg     <= '0;
            mode_reg      <= '{default: MODE_READY};
            delay_reg     <= '{default: '0};
            slicing_reg   <= 1'b0;
            tick_reg      <= '0;
            sw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            cur_reg       <= cur_next;
            ready_reg     <= ready_next;
            mode_reg      <= mode_next;
            delay_reg     <= delay_next;
            slicing_reg   <= slicing_next;
            tick_reg      <= tick_next;
            sw_reg        <= sw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    always_comb
    begin
        for (int i = 0; i < TASKS; i++)
        begin
            held_vec[i] = mode_reg[i] != MODE_READY;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= IDX_W'(TASKS))
        else $error("running slot out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped while a word is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !out_valid_reg)
        else $error("result word pending during delay walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (held_vec & ready_reg) == '0)
        else $error("delayed or suspended task in ready bitmap");

endmodule

// ----- rtl/priority_task_scheduler_core.sv -----
`timescale 1ns / 1ps
// path: an accepted word goes through the front stage register and the queue; create, plain
// suspend/resume and plain tick are then registered as the result word, a rescheduling command
// passes S_PICK first and a tick while running S_WALK then S_PICK; the back end pops the next
// word only back in S_IDLE (the tick walks one delay counter per cycle)
// reset: all tasks ready-mode but not in the bitmap, idle slot running, tick count zero,
// no time slicing until start
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// Bitmap priority task scheduler with tick delays: decode front, command queue
// and execution back end.
// ----------------------------------------------------------------------------
module priority_task_scheduler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  pts_pkg::cmd_word_t cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pts_pkg::rsp_word_t rsp_word
);
    import pts_pkg::*;

    logic     q_full;
    logic     push;
    op_word_t push_word;
    logic     pop;
    q_head_t  head;

    pts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    pts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    pts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority task scheduler. Command words go in
// over the valid/stall channel, and each is run through a bench-side scheduler
// model when it is accepted. Every response word is checked field by field
// against the oldest predicted word. Directed cases come first, then random
// command streams under several idle and stall mixes, a long response hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;

    import pts_pkg::*;

    // kinds with no package name; the block ignores them
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [3:0] IDLE_SLOT    = 4'(TASKS);

    typedef enum logic [1:0] {
        MODE_READY,
        MODE_DELAYED,
        MODE_SUSPENDED
    } slot_mode_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    // bench copy of the scheduler state
    logic [TASKS:0]          ready_map;
    slot_mode_t              slot_mode [TASKS+1];
    logic [DELAY_BITS-1:0]   slot_delay [TASKS+1];
    logic [3:0]              run_idx;
    logic                    slicing;
    logic [31:0]             tick_cnt;

    rsp_word_t due_rsp_q[$];
    int        fails         = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_len      = 0;

    priority_task_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void pick_lowest_ready();
        int i;
        run_idx = IDLE_SLOT;
        for (i = TASKS - 1; i >= 0; i--)
        begin
            if (ready_map[i])
                run_idx = 4'(i);
        end
    endfunction

    function automatic rsp_word_t schedule_cmd(cmd_word_t w);
        rsp_word_t             r;
        logic                  sw;
        logic [DELAY_BITS-1:0] dly;
        int                    i;
        sw  = 1'b0;
        dly = DELAY_BITS'(w.ticks);
        case (w.kind)
            KIND_CREATE:
            begin
                if (w.task_req <= TASKS)
                begin
                    ready_map[w.task_req]  = 1'b1;
                    slot_mode[w.task_req]  = MODE_READY;
                    slot_delay[w.task_req] = '0;
                end
            end
            KIND_SUSPEND:
            begin
                if (w.task_req <= TASKS)
                begin
                    slot_delay[w.task_req] = '0;
                    slot_mode[w.task_req]  = MODE_SUSPENDED;
                    ready_map[w.task_req]  = 1'b0;
                    if (run_idx == w.task_req)
                    begin
                        pick_lowest_ready();
                        sw = 1'b1;
                    end
                end
            end
            KIND_RESUME:
            begin
                if (w.task_req <= TASKS)
                begin
                    ready_map[w.task_req]  = 1'b1;
                    slot_delay[w.task_req] = '0;
                    slot_mode[w.task_req]  = MODE_READY;
                    if (run_idx == w.task_req)
                    begin
                        pick_lowest_ready();
                        sw = 1'b1;
                    end
                end
            end
            KIND_DELAY:
            begin
                // the running slot may be the idle one
                if (dly != '0)
                begin
                    ready_map[run_idx]  = 1'b0;
                    slot_delay[run_idx] = dly;
                    slot_mode[run_idx]  = MODE_DELAYED;
                    pick_lowest_ready();
                    sw = 1'b1;
                end
            end
            KIND_TICK:
            begin
                tick_cnt = tick_cnt + 1;
                if (slicing)
                begin
                    for (i = 0; i < TASKS; i++)
                    begin
                        if (slot_mode[i] == MODE_DELAYED)
                        begin
                            slot_delay[i] = slot_delay[i] - 1'b1;
                            if (slot_delay[i] == '0)
                            begin
                                slot_mode[i] = MODE_READY;
                                ready_map[i] = 1'b1;
                            end
                        end
                    end
                    pick_lowest_ready();
                    sw = 1'b1;
                end
            end
            KIND_START:
            begin
                ready_map[TASKS]  = 1'b1;
                slot_mode[TASKS]  = MODE_READY;
                slot_delay[TASKS] = '0;
                pick_lowest_ready();
                slicing = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.running_task   = run_idx;
        r.switch_request = sw;
        r.tick_total     = tick_cnt;
        return r;
    endfunction

    function automatic cmd_word_t make_cmd(logic [2:0] kind, int req, int dly);
        cmd_word_t w;
        w.kind     = kind;
        w.task_req = 4'(req);
        w.ticks    = 16'(dly);
        return w;
    endfunction

    // mostly well-formed traffic: short delays that expire, suspend/resume often
    // aimed at the running task, a few bad slots and unused kinds as noise
    function automatic cmd_word_t random_cmd();
        cmd_word_t   w;
        int unsigned pick;
        w.task_req = 4'($urandom_range(TASKS));
        w.ticks    = 16'($urandom);
        pick       = $urandom_range(99);
        if (pick < 14)
            w.kind = KIND_CREATE;
        else if (pick < 24)
            w.kind = KIND_SUSPEND;
        else if (pick < 34)
            w.kind = KIND_RESUME;
        else if (pick < 54)
            w.kind = KIND_DELAY;
        else if (pick < 93)
            w.kind = KIND_TICK;
        else if (pick < 96)
            w.kind = KIND_START;
        else
            w.kind = ($urandom_range(1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
        if ((w.kind == KIND_SUSPEND || w.kind == KIND_RESUME) && $urandom_range(99) < 40)
            w.task_req = run_idx;
        if ($urandom_range(99) < 6)
            w.task_req = 4'($urandom_range(15, TASKS + 1));
        if (w.kind == KIND_DELAY)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                w.ticks = '0;
            else if (pick < 85)
                w.ticks = 16'($urandom_range(6, 1));
        end
        return w;
    endfunction

    // offers one word and returns at the edge where it is accepted
    task automatic send_cmd(input cmd_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        due_rsp_q.push_back(schedule_cmd(w));
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_rsp_q.size() != 0);
    endtask

    // response side: check accepted words
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp_q.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected response word %h", $time, rsp_word);
            end
            else
            begin
                rsp_word_t want;
                want = due_rsp_q.pop_front();
                if (rsp_word.running_task !== want.running_task)
                begin
                    fails++;
                    $display("%0t: running_task expected %0d actual %0d", $time,
                             want.running_task, rsp_word.running_task);
                end
                if (rsp_word.switch_request !== want.switch_request)
                begin
                    fails++;
                    $display("%0t: switch_request expected %0d actual %0d", $time,
                             want.switch_request, rsp_word.switch_request);
                end
                if (rsp_word.tick_total !== want.tick_total)
                begin
                    fails++;
                    $display("%0t: tick_total expected %0d actual %0d", $time,
                             want.tick_total, rsp_word.tick_total);
                end
            end
        end
    end

    // receiver stall, with the long hold-off counted down in cycles
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_len  = hold_len - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic test_directed();
        // tick and delay of the idle slot before start
        send_cmd(make_cmd(KIND_TICK, 0, 16'hFFFF));
        send_cmd(make_cmd(KIND_DELAY, 0, 5));
        send_cmd(make_cmd(KIND_CREATE, 0, 0));
        send_cmd(make_cmd(KIND_CREATE, 3, 0));
        send_cmd(make_cmd(KIND_CREATE, 7, 0));
        send_cmd(make_cmd(KIND_CREATE, TASKS, 0));
        send_cmd(make_cmd(KIND_SUSPEND, 3, 0));
        send_cmd(make_cmd(KIND_START, 0, 0));
        // zero-length delay leaves everything alone
        send_cmd(make_cmd(KIND_DELAY, 0, 0));
        send_cmd(make_cmd(KIND_DELAY, 0, 2));
        send_cmd(make_cmd(KIND_TICK, 0, 0));
        send_cmd(make_cmd(KIND_TICK, 0, 0));
        send_cmd(make_cmd(KIND_RESUME, 0, 0));
        send_cmd(make_cmd(KIND_SUSPEND, 0, 0));
        send_cmd(make_cmd(KIND_RESUME, 3, 0));
        send_cmd(make_cmd(KIND_DELAY, 0, 16'hFFFF));
        send_cmd(make_cmd(KIND_SUSPEND, 3, 0));
        // all tasks out: the idle slot itself gets delayed
        send_cmd(make_cmd(KIND_DELAY, 0, 16'h8000));
        send_cmd(make_cmd(KIND_CREATE, 15, 16'h5555));
        send_cmd(make_cmd(KIND_SUSPEND, TASKS + 1, 16'hAAAA));
        send_cmd(make_cmd(KIND_RESUME, 12, 0));
        send_cmd(make_cmd(KIND_SPARE_A, 2, 1));
        send_cmd(make_cmd(KIND_SPARE_B, 5, 1));
        send_cmd(make_cmd(KIND_RESUME, 0, 0));
        send_cmd(make_cmd(KIND_TICK, 0, 0));
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_cmd(random_cmd());
    endtask

    // long response hold-off so the queue fills and the input stalls
    task automatic test_backpressure();
        hold_len = 400;
        test_random(30);
        wait_drain();
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drain();
        test_random(20);
    endtask

    initial
    begin
        int i;
        ready_map = '0;
        for (i = 0; i <= TASKS; i++)
        begin
            slot_mode[i]  = MODE_READY;
            slot_delay[i] = '0;
        end
        run_idx  = IDLE_SLOT;
        slicing  = 1'b0;
        tick_cnt = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(125);
        wait_drain();

        send_idle_pct = 79;
        test_random(125);
        wait_drain();

        send_idle_pct = 0;
        stall_pct     = 79;
        test_random(125);
        wait_drain();

        send_idle_pct = 36;
        stall_pct     = 36;
        test_random(125);
        wait_drain();

        send_idle_pct = 0;
        stall_pct     = 0;
        test_backpressure();
        test_drain_pause();

        wait_drain();
        repeat (TASKS + 10) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- priority_task_scheduler_core.f -----
rtl/pts_pkg.sv
rtl/pts_front.sv
rtl/pts_queue.sv
rtl/pts_back.sv
rtl/priority_task_scheduler_core.sv
tb/tb_top.sv
